/* hw/rtl/psm_pkg.sv */
// ----------------------------------------------------------------------------
// psm_pkg
// Shared types, sizes, command codes and id conversion helpers for the
// player/slot map table.
// ----------------------------------------------------------------------------
package psm_pkg;

    // Table geometry
    localparam int ROWS      = 8;
    localparam int PID_BITS  = 32;
    localparam int SLOTS     = 8;
    localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int SLOT_BITS = 4;

    // Empty slot marker (-1 in four bits)
    localparam logic [SLOT_BITS-1:0] SLOT_NONE = 4'hF;

    // Command codes
    localparam logic [2:0] CMD_CLEAR     = 3'd0;
    localparam logic [2:0] CMD_BIND      = 3'd1;
    localparam logic [2:0] CMD_SLOT_OF   = 3'd2;
    localparam logic [2:0] CMD_PLAYER_OF = 3'd3;
    localparam logic [2:0] CMD_SET_FLAG  = 3'd4;
    localparam logic [2:0] CMD_GET_FLAG  = 3'd5;

    typedef logic [PID_BITS-1:0] t_pid;

    // One table row as stored in memory
    typedef struct packed {
        t_pid                 pid;
        logic [SLOT_BITS-1:0] slot;
    } t_row;

    localparam int ROW_BITS = $bits(t_row);

    // Compare results for one row
    typedef struct packed {
        logic slot_hit;
        logic pid_hit;
        logic free;
    } t_hit;

    // Sign-extend a 32-bit port id to 64 bits, keep the stored width
    function automatic t_pid pid_from_port(input logic [31:0] v);
        logic signed [63:0] ext;
        ext = 64'(signed'(v));
        return ext[PID_BITS-1:0];
    endfunction

    // Sign-extend a stored id to 64 bits, keep the port width
    function automatic logic [31:0] pid_to_port(input t_pid v);
        logic signed [63:0] ext;
        ext = 64'(signed'(v));
        return ext[31:0];
    endfunction

endpackage

/* hw/rtl/psm_ram.sv */
// ----------------------------------------------------------------------------
// psm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module psm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/psm_match.sv */
// ----------------------------------------------------------------------------
// psm_match
// Shared row compare unit: resolves an empty row to -1/-1 and compares it
// against the search key by slot and by player id.
// ----------------------------------------------------------------------------
module psm_match (
    input  logic                           i_valid,
    input  psm_pkg::t_row                  i_row,
    input  psm_pkg::t_pid                  i_pid,
    input  logic [2:0]                     i_slot,
    output psm_pkg::t_row                  o_row,
    output psm_pkg::t_hit                  o_hit
);

    psm_pkg::t_row row_eff;

    // Substitute the empty marker for rows never written since clear
    always_comb begin
        if (i_valid) begin
            row_eff = i_row;
        end else begin
            row_eff.pid  = '1;
            row_eff.slot = psm_pkg::SLOT_NONE;
        end
    end

    // Compare against key
    assign o_hit.slot_hit = (row_eff.slot == {1'b0, i_slot});
    assign o_hit.pid_hit  = (row_eff.pid == i_pid);
    assign o_hit.free     = (row_eff.pid == '1);
    assign o_row          = row_eff;

endmodule

/* hw/rtl/player_slot_map_table_top.sv */
// ----------------------------------------------------------------------------
// player_slot_map_table_top
// Player id / slot association table with one flag bit per slot.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its single result
// appears on the o_ ports as o_done goes high for one cycle, and cannot be held
// off. Clear, set flag, get flag and unused codes need no scan; their result is
// registered directly. Bind and both lookups walk the rows one per cycle
// through the table RAM's registered read port and one shared compare unit,
// stopping at the first hit or after the last row. Clear resets per-row valid
// bits at once, so there is no clearing pass after reset.
// ----------------------------------------------------------------------------
module player_slot_map_table_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_cmd,
    input  logic [31:0] i_player_id,
    input  logic [2:0]  i_slot_index,
    input  logic        i_flag_value,
    output logic        o_done,
    output logic [3:0]  o_slot_out,
    output logic [31:0] o_player_out,
    output logic        o_flag_out,
    output logic        o_table_full
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    // Control state
    logic                       r_state, n_state;
    logic                       r_iss, n_iss;
    logic                       r_chk_on, n_chk_on;
    logic [psm_pkg::ROW_W-1:0]  r_idx, n_idx;
    logic [psm_pkg::ROW_W-1:0]  r_chk_idx, n_chk_idx;
    logic                       r_free_found, n_free_found;
    logic [psm_pkg::ROW_W-1:0]  r_free_row, n_free_row;
    logic [psm_pkg::ROWS-1:0]   r_valid, n_valid;
    logic [psm_pkg::SLOTS-1:0]  r_flags, n_flags;
    logic                       r_done, n_done;

    // Command key and results
    logic [2:0]                 r_cmd, n_cmd;
    psm_pkg::t_pid              r_pid, n_pid;
    logic [2:0]                 r_slot, n_slot;
    logic [3:0]                 r_slot_out, n_slot_out;
    logic [31:0]                r_player_out, n_player_out;
    logic                       r_flag_out, n_flag_out;
    logic                       r_full, n_full;

    // RAM and compare unit
    logic                       ram_we;
    logic [psm_pkg::ROW_W-1:0]  ram_waddr;
    psm_pkg::t_row              ram_wdata;
    psm_pkg::t_row              ram_rdata;
    psm_pkg::t_row              row_eff;
    psm_pkg::t_hit              hit;
    logic                       last_row;
    logic                       any_free;
    logic [psm_pkg::ROW_W-1:0]  free_row;

    psm_ram #(
        .WIDTH (psm_pkg::ROW_BITS),
        .DEPTH (psm_pkg::ROWS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    psm_match u_match (
        .i_valid (r_valid[r_chk_idx]),
        .i_row   (ram_rdata),
        .i_pid   (r_pid),
        .i_slot  (r_slot),
        .o_row   (row_eff),
        .o_hit   (hit)
    );

    assign last_row = (r_chk_idx == psm_pkg::ROW_W'(psm_pkg::ROWS - 1));
    assign any_free = r_free_found | hit.free;
    assign free_row = hit.free ? r_chk_idx : r_free_row;

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_iss        = r_iss;
        n_chk_on     = r_chk_on;
        n_idx        = r_idx;
        n_chk_idx    = r_chk_idx;
        n_free_found = r_free_found;
        n_free_row   = r_free_row;
        n_valid      = r_valid;
        n_flags      = r_flags;
        n_done       = 1'b0;
        n_cmd        = r_cmd;
        n_pid        = r_pid;
        n_slot       = r_slot;
        n_slot_out   = r_slot_out;
        n_player_out = r_player_out;
        n_flag_out   = r_flag_out;
        n_full       = r_full;
        ram_we       = 1'b0;
        ram_waddr    = r_chk_idx;
        ram_wdata    = row_eff;

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_cmd        = i_cmd;
                    n_pid        = psm_pkg::pid_from_port(i_player_id);
                    n_slot       = i_slot_index;
                    n_slot_out   = '0;
                    n_player_out = '0;
                    n_flag_out   = 1'b0;
                    n_full       = 1'b0;
                    unique case (i_cmd)
                        psm_pkg::CMD_CLEAR: begin
                            n_valid = '0;
                            n_flags = '0;
                            n_done  = 1'b1;
                        end
                        psm_pkg::CMD_BIND,
                        psm_pkg::CMD_SLOT_OF,
                        psm_pkg::CMD_PLAYER_OF: begin
                            n_state      = ST_SCAN;
                            n_iss        = 1'b1;
                            n_chk_on     = 1'b0;
                            n_idx        = '0;
                            n_free_found = 1'b0;
                        end
                        psm_pkg::CMD_SET_FLAG: begin
                            n_flags[i_slot_index] = i_flag_value;
                            n_done                = 1'b1;
                        end
                        psm_pkg::CMD_GET_FLAG: begin
                            n_flag_out = r_flags[i_slot_index];
                            n_done     = 1'b1;
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // Advance the read address; the RAM returns its data in the next cycle
                n_chk_on  = r_iss;
                n_chk_idx = r_idx;
                if (r_iss) begin
                    if (r_idx == psm_pkg::ROW_W'(psm_pkg::ROWS - 1)) begin
                        n_iss = 1'b0;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end

                // Check the row that arrived
                if (r_chk_on) begin
                    unique case (r_cmd)
                        psm_pkg::CMD_BIND: begin
                            priority if (hit.slot_hit) begin
                                ram_we        = 1'b1;
                                ram_waddr     = r_chk_idx;
                                ram_wdata.pid = r_pid;
                                n_state       = ST_IDLE;
                                n_done        = 1'b1;
                            end else if (last_row) begin
                                if (any_free) begin
                                    ram_we             = 1'b1;
                                    ram_waddr          = free_row;
                                    ram_wdata.pid      = r_pid;
                                    ram_wdata.slot     = {1'b0, r_slot};
                                    n_valid[free_row]  = 1'b1;
                                end else begin
                                    n_full = 1'b1;
                                end
                                n_state = ST_IDLE;
                                n_done  = 1'b1;
                            end else begin
                                n_free_found = any_free;
                                n_free_row   = free_row;
                            end
                        end
                        psm_pkg::CMD_SLOT_OF: begin
                            priority if (hit.pid_hit) begin
                                n_slot_out = row_eff.slot;
                                n_state    = ST_IDLE;
                                n_done     = 1'b1;
                            end else if (last_row) begin
                                n_slot_out = psm_pkg::SLOT_NONE;
                                n_state    = ST_IDLE;
                                n_done     = 1'b1;
                            end else begin
                                // keep scanning
                                n_state = ST_SCAN;
                            end
                        end
                        default: begin
                            priority if (hit.slot_hit) begin
                                n_player_out = psm_pkg::pid_to_port(row_eff.pid);
                                n_state      = ST_IDLE;
                                n_done       = 1'b1;
                            end else if (last_row) begin
                                n_player_out = '1;
                                n_state      = ST_IDLE;
                                n_done       = 1'b1;
                            end else begin
                                // keep scanning
                                n_state = ST_SCAN;
                            end
                        end
                    endcase
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_iss        <= 1'b0;
            r_chk_on     <= 1'b0;
            r_idx        <= '0;
            r_chk_idx    <= '0;
            r_free_found <= 1'b0;
            r_free_row   <= '0;
            r_valid      <= '0;
            r_flags      <= '0;
            r_done       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_iss        <= n_iss;
            r_chk_on     <= n_chk_on;
            r_idx        <= n_idx;
            r_chk_idx    <= n_chk_idx;
            r_free_found <= n_free_found;
            r_free_row   <= n_free_row;
            r_valid      <= n_valid;
            r_flags      <= n_flags;
            r_done       <= n_done;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_pid        <= n_pid;
        r_slot       <= n_slot;
        r_slot_out   <= n_slot_out;
        r_player_out <= n_player_out;
        r_flag_out   <= n_flag_out;
        r_full       <= n_full;
    end

    assign busy         = (r_state != ST_IDLE);
    assign o_done       = r_done;
    assign o_slot_out   = r_slot_out;
    assign o_player_out = r_player_out;
    assign o_flag_out   = r_flag_out;
    assign o_table_full = r_full;

endmodule
